### src/pps_timestamp_extender_assert.svh
// assertion macros used by the top-level rtl file pps_timestamp_extender.sv
`ifndef PPS_TIMESTAMP_EXTENDER_ASSERT_SVH
`define PPS_TIMESTAMP_EXTENDER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pps_timestamp_extender: assertion failed");

// consequent must hold in the cycle after the antecedent
`define PPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pps_timestamp_extender: assertion failed");

`endif

### src/pps_ts_pkg.sv
package pps_ts_pkg;

  localparam int unsigned CntW = 32;
  localparam int unsigned SeqW = 64;

  localparam logic [CntW-1:0] RESET_PERIOD = 32'd24000000;
  // reload value is two's complement of the period
  localparam logic [CntW-1:0] RESET_RELOAD = ~RESET_PERIOD + 32'd1;

  localparam logic FUNC_EVENT = 1'b0;
  localparam logic FUNC_QUEUE = 1'b1;

  typedef struct packed {
    logic            func;
    logic            overflow_flag;
    logic            capture_flag;
    logic [CntW-1:0] counter_now;
    logic [CntW-1:0] captured_count;
    logic [CntW-1:0] adjust_value;
  } item_t;

  typedef struct packed {
    logic [SeqW-1:0] tick_seq;
    logic [CntW-1:0] prev_reload;
    logic [CntW-1:0] cur_reload;
    logic [CntW-1:0] pend_adjust;
  } state_t;

  typedef struct packed {
    logic            overflow_seen;
    logic [SeqW-1:0] overflow_event_seq;
    logic [SeqW-1:0] overflow_irq_seq;
    logic [CntW-1:0] load_value;
    logic [CntW-1:0] match_value;
    logic            capture_seen;
    logic [SeqW-1:0] capture_event_seq;
    logic [SeqW-1:0] capture_irq_seq;
  } result_t;

endpackage

### src/pps_timestamp_extender.sv
// pps timestamp extender
// input channel (in_valid_i / in_ready_o) takes one word per timer interrupt
// or per queued one-shot period adjustment (func_i high). output channel
// (out_valid_o / out_ready_i) returns exactly one result word for each input
// word, in order. nominal_period is written through cfg_we_i / cfg_wdata_i
// while the block is idle, a user rule the block does not enforce; it takes
// effect at the next overflow. a word passes an input register and a result
// register before out_valid_o rises; one word per cycle passes while the
// receiver takes each result. the tick/reload state is read and updated in
// the cycle a word moves from the input register to the result register.
// reset empties both registers and clears the 64-bit tick sequence, the
// previous reload and the queued adjustment; the current reload becomes 2^32
// minus 24000000 and nominal_period returns to 24000000.
// when the receiver stalls the result holds; one more word waits in the
// input register, then in_ready_o drops until the result is taken.
`include "pps_timestamp_extender_assert.svh"

module pps_timestamp_extender (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic        overflow_flag_i,
  input  logic        capture_flag_i,
  input  logic [31:0] counter_now_i,
  input  logic [31:0] captured_count_i,
  input  logic [31:0] adjust_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        overflow_seen_o,
  output logic [63:0] overflow_event_seq_o,
  output logic [63:0] overflow_irq_seq_o,
  output logic [31:0] load_value_o,
  output logic [31:0] match_value_o,
  output logic        capture_seen_o,
  output logic [63:0] capture_event_seq_o,
  output logic [63:0] capture_irq_seq_o
);

  pps_ts_pkg::item_t           item_q;
  logic                        item_valid_q;
  pps_ts_pkg::result_t         out_q;
  logic                        out_valid_q;
  pps_ts_pkg::state_t          state;
  pps_ts_pkg::state_t          state_d;
  pps_ts_pkg::result_t         result_d;
  logic [pps_ts_pkg::CntW-1:0] nominal_period;
  logic                        out_free;
  logic                        fire;
  logic                        in_accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = item_valid_q && out_free;
  assign in_ready_o = !item_valid_q || out_free;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.func           <= func_i;
      item_q.overflow_flag  <= overflow_flag_i;
      item_q.capture_flag   <= capture_flag_i;
      item_q.counter_now    <= counter_now_i;
      item_q.captured_count <= captured_count_i;
      item_q.adjust_value   <= adjust_value_i;
    end
  end

  pps_ts_state u_state (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .update_i         (fire),
    .state_d_i        (state_d),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .state_o          (state),
    .nominal_period_o (nominal_period)
  );

  pps_ts_calc u_calc (
    .item_i           (item_q),
    .state_i          (state),
    .nominal_period_i (nominal_period),
    .state_o          (state_d),
    .result_o         (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign overflow_seen_o      = out_q.overflow_seen;
  assign overflow_event_seq_o = out_q.overflow_event_seq;
  assign overflow_irq_seq_o   = out_q.overflow_irq_seq;
  assign load_value_o         = out_q.load_value;
  assign match_value_o        = out_q.match_value;
  assign capture_seen_o       = out_q.capture_seen;
  assign capture_event_seq_o  = out_q.capture_event_seq;
  assign capture_irq_seq_o    = out_q.capture_irq_seq;

  `PPS_ASSERT_NEXT(a_queue_adjust, clk_i, rst_ni,
    fire && (item_q.func == pps_ts_pkg::FUNC_QUEUE),
    state.pend_adjust == $past(item_q.adjust_value))
  `PPS_ASSERT_NEXT(a_ovf_update, clk_i, rst_ni,
    fire && (item_q.func == pps_ts_pkg::FUNC_EVENT) && item_q.overflow_flag,
    (state.pend_adjust == '0) && (state.prev_reload == $past(state.cur_reload)))
  `PPS_ASSERT_NEXT(a_item_held, clk_i, rst_ni,
    item_valid_q && !out_free, item_valid_q)
  `PPS_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, fire, out_valid_q)

endmodule

### src/pps_ts_calc.sv
module pps_ts_calc (
  input  pps_ts_pkg::item_t         item_i,
  input  pps_ts_pkg::state_t        state_i,
  input  logic [pps_ts_pkg::CntW-1:0] nominal_period_i,
  output pps_ts_pkg::state_t        state_o,
  output pps_ts_pkg::result_t       result_o
);

  logic [pps_ts_pkg::CntW-1:0] prev_ticks;
  logic [pps_ts_pkg::CntW-1:0] period;
  logic [pps_ts_pkg::CntW-1:0] period_sum;
  logic [pps_ts_pkg::SeqW-1:0] tick_ovf;
  logic [pps_ts_pkg::SeqW-1:0] tick_base;
  logic [pps_ts_pkg::CntW-1:0] base_reload;
  logic [pps_ts_pkg::CntW-1:0] cnt_from_cur;
  logic [pps_ts_pkg::CntW-1:0] cnt_from_prev;
  logic [pps_ts_pkg::CntW-1:0] cap_from_base;
  logic [pps_ts_pkg::CntW-1:0] cap_period;
  logic [pps_ts_pkg::SeqW-1:0] irq_late;
  logic [pps_ts_pkg::SeqW-1:0] irq_early;
  logic [pps_ts_pkg::SeqW-1:0] ev_plain;
  logic [pps_ts_pkg::SeqW-1:0] ev_before;
  logic                        cap_after_read;

  assign prev_ticks     = ~state_i.prev_reload + 32'd1;
  assign period         = ~state_i.cur_reload + 32'd1;
  assign period_sum     = nominal_period_i + state_i.pend_adjust;
  assign tick_ovf       = state_i.tick_seq + {32'd0, prev_ticks};
  assign tick_base      = item_i.overflow_flag ? tick_ovf : state_i.tick_seq;
  // after an overflow the reload that counts is the one just loaded
  assign base_reload    = item_i.overflow_flag ? state_i.cur_reload : state_i.prev_reload;
  assign cnt_from_cur   = item_i.counter_now - state_i.cur_reload;
  assign cnt_from_prev  = item_i.counter_now - state_i.prev_reload;
  assign cap_from_base  = item_i.captured_count - base_reload;
  assign cap_period     = ~item_i.captured_count + 32'd1;
  assign cap_after_read = item_i.captured_count > item_i.counter_now;

  assign irq_late  = tick_ovf + {32'd0, cnt_from_cur};
  assign irq_early = state_i.tick_seq + {32'd0, cnt_from_prev};
  assign ev_plain  = tick_base + {32'd0, cap_from_base};
  assign ev_before = tick_ovf - {32'd0, cap_period};

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (item_i.func == pps_ts_pkg::FUNC_QUEUE) begin
      state_o.pend_adjust = item_i.adjust_value;
    end else begin
      if (item_i.overflow_flag) begin
        state_o.tick_seq    = tick_ovf;
        state_o.prev_reload = state_i.cur_reload;
        state_o.cur_reload  = ~period_sum + 32'd1;
        state_o.pend_adjust = '0;
        result_o.overflow_seen      = 1'b1;
        result_o.overflow_event_seq = tick_ovf;
        result_o.overflow_irq_seq   = irq_late;
        result_o.load_value         = ~period_sum + 32'd1;
        result_o.match_value        = ~(period >> 1) + 32'd1;
      end
      if (item_i.capture_flag) begin
        result_o.capture_seen      = 1'b1;
        result_o.capture_event_seq =
          (item_i.overflow_flag && cap_after_read) ? ev_before : ev_plain;
        // edge before the reload but read after it: read counts from the new reload
        result_o.capture_irq_seq   =
          (item_i.overflow_flag || cap_after_read) ? irq_late : irq_early;
      end
    end
  end

endmodule

### src/pps_ts_state.sv
module pps_ts_state (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        update_i,
  input  pps_ts_pkg::state_t          state_d_i,
  input  logic                        cfg_we_i,
  input  logic [pps_ts_pkg::CntW-1:0] cfg_wdata_i,
  output pps_ts_pkg::state_t          state_o,
  output logic [pps_ts_pkg::CntW-1:0] nominal_period_o
);

  pps_ts_pkg::state_t          state_q;
  logic [pps_ts_pkg::CntW-1:0] nominal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.tick_seq    <= '0;
      state_q.prev_reload <= '0;
      state_q.cur_reload  <= pps_ts_pkg::RESET_RELOAD;
      state_q.pend_adjust <= '0;
    end else if (update_i) begin
      state_q <= state_d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nominal_q <= pps_ts_pkg::RESET_PERIOD;
    end else if (cfg_we_i) begin
      nominal_q <= cfg_wdata_i;
    end
  end

  assign state_o          = state_q;
  assign nominal_period_o = nominal_q;

endmodule

### dv/pps_ts_checker.sv
module pps_ts_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              func_i,
  input  logic              overflow_flag_i,
  input  logic              capture_flag_i,
  input  logic [31:0]       counter_now_i,
  input  logic [31:0]       captured_count_i,
  input  logic [31:0]       adjust_value_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              overflow_seen_i,
  input  logic [63:0]       overflow_event_seq_i,
  input  logic [63:0]       overflow_irq_seq_i,
  input  logic [31:0]       load_value_i,
  input  logic [31:0]       match_value_i,
  input  logic              capture_seen_i,
  input  logic [63:0]       capture_event_seq_i,
  input  logic [63:0]       capture_irq_seq_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0]         seq_acc;
  logic [31:0]         prev_rl;
  logic [31:0]         cur_rl;
  logic [31:0]         adj_q;
  logic [31:0]         period_reg;
  pps_ts_pkg::result_t due_results[$];
  pps_ts_pkg::result_t want;
  pps_ts_pkg::item_t   word_in;
  pps_ts_pkg::result_t word_out;

  assign word_in = {func_i, overflow_flag_i, capture_flag_i, counter_now_i,
                    captured_count_i, adjust_value_i};
  assign word_out = {overflow_seen_i, overflow_event_seq_i, overflow_irq_seq_i,
                     load_value_i, match_value_i, capture_seen_i,
                     capture_event_seq_i, capture_irq_seq_i};

  // ticks in one period for a reload value, wraps modulo 2^32
  function automatic logic [31:0] ticks_of(logic [31:0] rl);
    return 32'd0 - rl;
  endfunction

  function automatic pps_ts_pkg::result_t extend_timestamp(pps_ts_pkg::item_t it);
    pps_ts_pkg::result_t r;
    logic [31:0]         last_ticks;
    logic [31:0]         cur_ticks;
    logic [31:0]         sum;
    logic [63:0]         irq_seq;
    r = '0;
    irq_seq = '0;
    if (it.func == pps_ts_pkg::FUNC_QUEUE) begin
      adj_q = it.adjust_value;
      return r;
    end
    last_ticks = ticks_of(prev_rl);
    cur_ticks = ticks_of(cur_rl);
    if (it.overflow_flag) begin
      seq_acc = seq_acc + {32'd0, last_ticks};
      prev_rl = cur_rl;
      sum = period_reg + adj_q;
      cur_rl = ticks_of(sum);
      adj_q = '0;
      irq_seq = seq_acc + {32'd0, it.counter_now - prev_rl};
      r.overflow_seen = 1'b1;
      r.overflow_event_seq = seq_acc;
      r.overflow_irq_seq = irq_seq;
      r.load_value = cur_rl;
      r.match_value = ticks_of(cur_ticks >> 1);
    end
    if (it.capture_flag) begin
      r.capture_seen = 1'b1;
      if (it.overflow_flag) begin
        r.capture_irq_seq = irq_seq;
        // edge came before the reload: count back from the overflow instant
        if (it.captured_count > it.counter_now)
          r.capture_event_seq = seq_acc - {32'd0, ticks_of(it.captured_count)};
        else
          r.capture_event_seq = seq_acc + {32'd0, it.captured_count - prev_rl};
      end else begin
        r.capture_event_seq = seq_acc + {32'd0, it.captured_count - prev_rl};
        // read happened after an unreported reload
        if (it.captured_count > it.counter_now)
          r.capture_irq_seq = seq_acc + {32'd0, last_ticks}
                              + {32'd0, it.counter_now - cur_rl};
        else
          r.capture_irq_seq = seq_acc + {32'd0, it.counter_now - prev_rl};
      end
    end
    return r;
  endfunction

  task automatic cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s expected %h got %h", $time, name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_reg = pps_ts_pkg::RESET_PERIOD;
      seq_acc = '0;
      prev_rl = '0;
      cur_rl = ticks_of(pps_ts_pkg::RESET_PERIOD);
      adj_q = '0;
      due_results.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) period_reg = cfg_wdata_i;
      if (in_valid_i && in_ready_i) due_results.push_back(extend_timestamp(word_in));
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          $display("%0t unexpected word expected none got %h", $time, word_out);
          errors_o++;
        end else begin
          want = due_results.pop_front();
          cmp_field("overflow_seen", want.overflow_seen, word_out.overflow_seen);
          cmp_field("overflow_event_seq", want.overflow_event_seq,
                    word_out.overflow_event_seq);
          cmp_field("overflow_irq_seq", want.overflow_irq_seq, word_out.overflow_irq_seq);
          cmp_field("load_value", want.load_value, word_out.load_value);
          cmp_field("match_value", want.match_value, word_out.match_value);
          cmp_field("capture_seen", want.capture_seen, word_out.capture_seen);
          cmp_field("capture_event_seq", want.capture_event_seq,
                    word_out.capture_event_seq);
          cmp_field("capture_irq_seq", want.capture_irq_seq, word_out.capture_irq_seq);
        end
      end
    end
    pending_o = due_results.size();
  end

endmodule

### dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        func;
  logic        ovf_flag;
  logic        cap_flag;
  logic [31:0] count_now;
  logic [31:0] cap_count;
  logic [31:0] adj_val;
  logic        out_valid;
  logic        out_ready;
  logic        ovf_seen;
  logic [63:0] ovf_event_seq;
  logic [63:0] ovf_irq_seq;
  logic [31:0] load_value;
  logic [31:0] match_value;
  logic        cap_seen;
  logic [63:0] cap_event_seq;
  logic [63:0] cap_irq_seq;
  int unsigned errors;
  int unsigned pending;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic [31:0] period_now;
  logic [31:0] reload_hint;

  pps_timestamp_extender dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .func_i              (func),
    .overflow_flag_i     (ovf_flag),
    .capture_flag_i      (cap_flag),
    .counter_now_i       (count_now),
    .captured_count_i    (cap_count),
    .adjust_value_i      (adj_val),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .overflow_seen_o     (ovf_seen),
    .overflow_event_seq_o(ovf_event_seq),
    .overflow_irq_seq_o  (ovf_irq_seq),
    .load_value_o        (load_value),
    .match_value_o       (match_value),
    .capture_seen_o      (cap_seen),
    .capture_event_seq_o (cap_event_seq),
    .capture_irq_seq_o   (cap_irq_seq)
  );

  pps_ts_checker u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .func_i              (func),
    .overflow_flag_i     (ovf_flag),
    .capture_flag_i      (cap_flag),
    .counter_now_i       (count_now),
    .captured_count_i    (cap_count),
    .adjust_value_i      (adj_val),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .overflow_seen_i     (ovf_seen),
    .overflow_event_seq_i(ovf_event_seq),
    .overflow_irq_seq_i  (ovf_irq_seq),
    .load_value_i        (load_value),
    .match_value_i       (match_value),
    .capture_seen_i      (cap_seen),
    .capture_event_seq_i (cap_event_seq),
    .capture_irq_seq_i   (cap_irq_seq),
    .errors_o            (errors),
    .pending_o           (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_word(logic f, logic ov, logic cp, logic [31:0] cnt,
                           logic [31:0] capc, logic [31:0] adj);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    ovf_flag <= ov;
    cap_flag <= cp;
    count_now <= cnt;
    cap_count <= capc;
    adj_val <= adj;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained(int unsigned settle);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_period(logic [31:0] v);
    wait_drained(4);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    period_now = v;
    reload_hint = 32'd0 - v;
  endtask

  // counter values: extremes, noise, and values inside the running period
  function automatic logic [31:0] pick_count();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return $urandom;
      3: return 32'hffff_ffff - $urandom_range(255);
      default: return reload_hint + ($urandom % period_now);
    endcase
  endfunction

  task automatic send_random_word();
    logic [31:0] adj;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(2))
        0: adj = $urandom_range(1000);
        1: adj = 32'd0 - $urandom_range(1000);
        default: adj = $urandom;
      endcase
      push_word(pps_ts_pkg::FUNC_QUEUE, 1'($urandom_range(1)), 1'($urandom_range(1)),
                $urandom, $urandom, adj);
    end else begin
      push_word(pps_ts_pkg::FUNC_EVENT, 1'($urandom_range(1)), 1'($urandom_range(1)),
                pick_count(), pick_count(), $urandom);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    func = pps_ts_pkg::FUNC_EVENT;
    ovf_flag = 1'b0;
    cap_flag = 1'b0;
    count_now = '0;
    cap_count = '0;
    adj_val = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    period_now = pps_ts_pkg::RESET_PERIOD;
    reload_hint = 32'd0 - pps_ts_pkg::RESET_PERIOD;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset period, first overflow adds nothing
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b0, 1'b0, $urandom, $urandom, 32'hffff_ffff);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b1, 1'b0, reload_hint + 32'd5, 32'd0, 32'd0);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b1, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'd0);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b0, 1'b1, 32'd0, 32'hffff_ffff, 32'd0);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b0, 1'b1, 32'hffff_ffff, 32'd0, 32'd0);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b1, 1'b1, reload_hint + 32'd3, 32'hffff_fff0,
              32'd0);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b1, 1'b1, reload_hint + 32'd9, reload_hint + 32'd9,
              32'd0);
    // queued adjustments: all ones, replaced, and one that wraps the sum to zero
    push_word(pps_ts_pkg::FUNC_QUEUE, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b1, 1'b0, $urandom, $urandom, 32'd0);
    push_word(pps_ts_pkg::FUNC_QUEUE, 1'b0, 1'b0, 32'd0, 32'd0, 32'd5);
    push_word(pps_ts_pkg::FUNC_QUEUE, 1'b0, 1'b0, 32'd0, 32'd0, 32'd7);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b1, 1'b1, $urandom, $urandom, 32'd0);
    push_word(pps_ts_pkg::FUNC_QUEUE, 1'b0, 1'b0, 32'd0, 32'd0,
              32'd0 - pps_ts_pkg::RESET_PERIOD);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b1, 1'b0, $urandom, $urandom, 32'd0);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b1, 1'b1, $urandom, $urandom, 32'd0);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b1, 1'b0, $urandom, $urandom, 32'd0);

    write_period(32'hffff_ffff);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b1, 1'b0, $urandom, $urandom, 32'd0);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b1, 1'b1, 32'd1, 32'd2, 32'd0);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b0, 1'b1, 32'd2, 32'd1, 32'd0);
    write_period(32'd1);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b1, 1'b0, 32'hffff_ffff, 32'd0, 32'd0);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'd0);
    push_word(pps_ts_pkg::FUNC_EVENT, 1'b0, 1'b1, $urandom, $urandom, 32'd0);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          write_period($urandom_range(32'hffff_ffff, 1));
          send_idle_pct = 10;
          recv_idle_pct = 72;
        end
        1: begin
          write_period($urandom_range(64, 1));
          send_idle_pct = 72;
          recv_idle_pct = 10;
        end
        default: begin
          write_period(pps_ts_pkg::RESET_PERIOD);
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (235) send_random_word();
    end

    wait_drained(10);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
